### rtl/core/bdps_pkg.sv
package bdps_pkg;

   localparam int MAX_DIFFS_DEFAULT   = 15;
   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam int BYTE_BITS       = 8;
   localparam int LEN_BITS        = 4;
   localparam int DIFFS_LOW_BITS  = 64;
   localparam int DIFFS_HIGH_BITS = 56;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 64;
   localparam int OFFSET_OUT_BITS = 32;
   localparam int DIFF_ALL_BITS   = (1 << LEN_BITS) * BYTE_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_DIFFS_LOW      = 2'd1,
      CSR_DIFFS_HIGH     = 2'd2
   } csr_index_type;

   // difference i of the pattern; slot 15 reads as zero
   function automatic logic [BYTE_BITS-1:0] diff_at(
      input logic [DIFFS_LOW_BITS-1:0]  diffs_low,
      input logic [DIFFS_HIGH_BITS-1:0] diffs_high,
      input logic [LEN_BITS-1:0]        idx
   );
      logic [DIFF_ALL_BITS-1:0] all_diffs;
      all_diffs = {{(DIFF_ALL_BITS - DIFFS_LOW_BITS - DIFFS_HIGH_BITS){1'b0}},
                   diffs_high, diffs_low};
      return all_diffs[{idx, 3'b000} +: BYTE_BITS];
   endfunction

endpackage

### rtl/core/bdps_window.sv
module bdps_window #(
   parameter int MAX_DIFFS   = bdps_pkg::MAX_DIFFS_DEFAULT,
   parameter int OFFSET_BITS = bdps_pkg::OFFSET_BITS_DEFAULT,
   parameter int DEPTH       = MAX_DIFFS + 1,
   parameter int FILL_BITS   = $clog2(DEPTH + 1)
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  logic [bdps_pkg::BYTE_BITS-1:0]                 req_tdata,
   input  logic [bdps_pkg::LEN_BITS-1:0]                  pattern_length,
   input  logic                                           advance,
   output logic                                           window_valid,
   output logic [DEPTH-1:0][bdps_pkg::BYTE_BITS-1:0]      window_bytes,
   output logic [FILL_BITS-1:0]                           window_fill,
   output logic [OFFSET_BITS-1:0]                         window_start
);

   localparam int LIM_BITS = (FILL_BITS > bdps_pkg::LEN_BITS + 1) ?
                             FILL_BITS : bdps_pkg::LEN_BITS + 1;

   logic                                      valid_ff, valid_in;
   logic [DEPTH-1:0][bdps_pkg::BYTE_BITS-1:0] bytes_ff, bytes_in;
   logic [FILL_BITS-1:0]                      fill_ff, fill_in;
   logic [OFFSET_BITS-1:0]                    start_ff, start_in;
   logic [LIM_BITS-1:0]                       limit;
   logic                                      load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      limit = LIM_BITS'(pattern_length) + LIM_BITS'(1);
      if (limit > LIM_BITS'(DEPTH)) begin
         limit = LIM_BITS'(DEPTH);
      end

      valid_in = valid_ff;
      bytes_in = bytes_ff;
      fill_in  = fill_ff;
      start_in = start_ff;
      if (load) begin
         valid_in = 1'b1;
         bytes_in = {bytes_ff[DEPTH-2:0], req_tdata};
         if (LIM_BITS'(fill_ff) >= limit) begin
            start_in = start_ff + OFFSET_BITS'(1);
         end else begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fill_ff  <= '0;
         start_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign window_valid = valid_ff;
   assign window_bytes = bytes_ff;
   assign window_fill  = fill_ff;
   assign window_start = start_ff;

endmodule

### rtl/core/bdps_match.sv
module bdps_match #(
   parameter int MAX_DIFFS   = bdps_pkg::MAX_DIFFS_DEFAULT,
   parameter int OFFSET_BITS = bdps_pkg::OFFSET_BITS_DEFAULT,
   parameter int DEPTH       = MAX_DIFFS + 1,
   parameter int FILL_BITS   = $clog2(DEPTH + 1)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      window_valid,
   input  logic [DEPTH-1:0][bdps_pkg::BYTE_BITS-1:0] window_bytes,
   input  logic [FILL_BITS-1:0]                      window_fill,
   input  logic [OFFSET_BITS-1:0]                    window_start,
   input  logic [bdps_pkg::LEN_BITS-1:0]             pattern_length,
   input  logic [bdps_pkg::DIFFS_LOW_BITS-1:0]       diffs_low,
   input  logic [bdps_pkg::DIFFS_HIGH_BITS-1:0]      diffs_high,
   output logic                                      advance,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [bdps_pkg::OFFSET_OUT_BITS-1:0]      rsp_tdata,
   output logic                                      rsp_tuser
);

   localparam int LIM_BITS = (FILL_BITS > bdps_pkg::LEN_BITS + 1) ?
                             FILL_BITS : bdps_pkg::LEN_BITS + 1;

   logic                                          rsp_valid_ff, rsp_valid_in;
   logic [bdps_pkg::OFFSET_OUT_BITS-1:0]          offset_ff;
   logic                                          found_ff;
   logic                                          found;
   logic [OFFSET_BITS+bdps_pkg::OFFSET_OUT_BITS-1:0] start_ext;

   always_comb begin
      logic [LIM_BITS-1:0]            len_ext;
      logic [bdps_pkg::BYTE_BITS-1:0] sel;
      logic [bdps_pkg::BYTE_BITS-1:0] sum;
      len_ext = LIM_BITS'(pattern_length);
      found   = (pattern_length != '0) && (len_ext <= LIM_BITS'(MAX_DIFFS)) &&
                (LIM_BITS'(window_fill) == len_ext + LIM_BITS'(1));
      // pair j is window[j+1] -> window[j]; it checks difference len-1-j
      for (int j = 0; j < MAX_DIFFS; j++) begin
         sel = bdps_pkg::diff_at(diffs_low, diffs_high,
                                 bdps_pkg::LEN_BITS'(int'(pattern_length) - 1 - j));
         sum = window_bytes[j+1] + sel;
         if (LIM_BITS'(j) < len_ext && sum != window_bytes[j]) begin
            found = 1'b0;
         end
      end
   end

   assign start_ext = {{bdps_pkg::OFFSET_OUT_BITS{1'b0}}, window_start};

   assign advance = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = window_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && window_valid) begin
         found_ff  <= found;
         offset_ff <= start_ext[bdps_pkg::OFFSET_OUT_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = offset_ff;
   assign rsp_tuser  = found_ff;

endmodule

### rtl/core/byte_difference_pattern_search_unit.sv
// An accepted req beat is shifted into the window register; its result is held in the rsp register.
// Throughput: one beat per cycle while the rsp side is not stalled; the parallel difference
// compares sit between the window register and the rsp register.
// Reset (synchronous, active high): window empty, offset zero, all
// configuration registers zero, no rsp beat pending.
module byte_difference_pattern_search_unit #(
   parameter int MAX_DIFFS   = bdps_pkg::MAX_DIFFS_DEFAULT,
   parameter int OFFSET_BITS = bdps_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bdps_pkg::BYTE_BITS-1:0]        req_tdata,   // data_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bdps_pkg::OFFSET_OUT_BITS-1:0]  rsp_tdata,   // match_offset
   output logic                                  rsp_tuser,   // match_found
   input  logic                                  csr_we,
   input  logic [bdps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bdps_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int DEPTH     = MAX_DIFFS + 1;
   localparam int FILL_BITS = $clog2(DEPTH + 1);

   logic [bdps_pkg::LEN_BITS-1:0]        pattern_length_ff, pattern_length_in;
   logic [bdps_pkg::DIFFS_LOW_BITS-1:0]  diffs_low_ff, diffs_low_in;
   logic [bdps_pkg::DIFFS_HIGH_BITS-1:0] diffs_high_ff, diffs_high_in;

   logic                                      advance;
   logic                                      window_valid;
   logic [DEPTH-1:0][bdps_pkg::BYTE_BITS-1:0] window_bytes;
   logic [FILL_BITS-1:0]                      window_fill;
   logic [OFFSET_BITS-1:0]                    window_start;

   always_comb begin
      pattern_length_in = pattern_length_ff;
      diffs_low_in      = diffs_low_ff;
      diffs_high_in     = diffs_high_ff;
      if (csr_we) begin
         unique case (bdps_pkg::csr_index_type'(csr_index))
            bdps_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_wdata[bdps_pkg::LEN_BITS-1:0];
            end
            bdps_pkg::CSR_DIFFS_LOW: begin
               diffs_low_in = csr_wdata[bdps_pkg::DIFFS_LOW_BITS-1:0];
            end
            bdps_pkg::CSR_DIFFS_HIGH: begin
               diffs_high_in = csr_wdata[bdps_pkg::DIFFS_HIGH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         diffs_low_ff      <= '0;
         diffs_high_ff     <= '0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         diffs_low_ff      <= diffs_low_in;
         diffs_high_ff     <= diffs_high_in;
      end
   end

   bdps_window #(
      .MAX_DIFFS   (MAX_DIFFS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .pattern_length (pattern_length_ff),
      .advance        (advance),
      .window_valid   (window_valid),
      .window_bytes   (window_bytes),
      .window_fill    (window_fill),
      .window_start   (window_start)
   );

   bdps_match #(
      .MAX_DIFFS   (MAX_DIFFS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_match (
      .clock          (clock),
      .reset          (reset),
      .window_valid   (window_valid),
      .window_bytes   (window_bytes),
      .window_fill    (window_fill),
      .window_start   (window_start),
      .pattern_length (pattern_length_ff),
      .diffs_low      (diffs_low_ff),
      .diffs_high     (diffs_high_ff),
      .advance        (advance),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      window_fill <= FILL_BITS'(DEPTH))
      else $error("window fill beyond depth");

   a_start_only_on_beat: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) |=> $stable(window_start))
      else $error("window offset moved without a req beat");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (window_valid && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("req beat taken while window result is stalled");

   a_rsp_from_window: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(window_valid))
      else $error("rsp beat without a window result");

endmodule

### bench/tb_byte_difference_pattern_search_unit.sv
`timescale 1ns / 100ps

module tb_byte_difference_pattern_search_unit;

   localparam int          CLK_PERIOD     = 10;
   localparam int          RESET_CYCLES   = 12;
   localparam int          WINDOW_DEPTH   = bdps_pkg::MAX_DIFFS_DEFAULT + 1;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          PHASE_BEATS    = 91;
   localparam logic [bdps_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      bit                                  hit;
      bit [bdps_pkg::OFFSET_OUT_BITS-1:0]  offset;
   } window_verdict_type;

   class diff_match_predictor;
      bit [bdps_pkg::BYTE_BITS-1:0]        recent_bytes [WINDOW_DEPTH];
      int unsigned                         fill_count    = 0;
      bit [bdps_pkg::OFFSET_OUT_BITS-1:0]  oldest_offset = '0;
      bit [bdps_pkg::LEN_BITS-1:0]         span          = '0;
      bit [bdps_pkg::DIFFS_LOW_BITS-1:0]   steps_low     = '0;
      bit [bdps_pkg::DIFFS_HIGH_BITS-1:0]  steps_high    = '0;
      window_verdict_type                  expected_hits [$];
      int unsigned                         faults        = 0;

      function void write_register(logic [bdps_pkg::CSR_INDEX_BITS-1:0] idx,
                                   logic [bdps_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            bdps_pkg::CSR_PATTERN_LENGTH: span      = value[bdps_pkg::LEN_BITS-1:0];
            bdps_pkg::CSR_DIFFS_LOW:      steps_low = value[bdps_pkg::DIFFS_LOW_BITS-1:0];
            bdps_pkg::CSR_DIFFS_HIGH: steps_high = value[bdps_pkg::DIFFS_HIGH_BITS-1:0];
            default: ;
         endcase
      endfunction

      function bit [bdps_pkg::BYTE_BITS-1:0] step_at(int i);
         if (i < 8) return steps_low[8*i +: 8];
         if (i < 15) return steps_high[8*(i-8) +: 8];
         return '0;
      endfunction

      function void absorb_byte(bit [bdps_pkg::BYTE_BITS-1:0] value);
         int unsigned                   limit;
         bit                            hit;
         bit [bdps_pkg::BYTE_BITS-1:0]  sum;
         window_verdict_type            verdict;
         limit = span + 1;
         if (limit > WINDOW_DEPTH) limit = WINDOW_DEPTH;
         for (int k = WINDOW_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
         recent_bytes[0] = value;
         if (fill_count >= limit) oldest_offset++;
         else fill_count++;
         hit = (span != 0) && (fill_count == span + 1);
         for (int i = 0; i < span; i++) begin
            sum = recent_bytes[span - i] + step_at(i);
            if (sum != recent_bytes[span - i - 1]) hit = 1'b0;
         end
         verdict.hit    = hit;
         verdict.offset = oldest_offset;
         expected_hits.insert(expected_hits.size(), verdict);
      endfunction

      function void check_beat(bit found, bit [bdps_pkg::OFFSET_OUT_BITS-1:0] offset);
         window_verdict_type want;
         if (expected_hits.size() == 0) begin
            faults++;
            $display("%0t: unexpected rsp beat, got match_found %0b match_offset %h",
                     $time, found, offset);
            return;
         end
         want = expected_hits[0];
         expected_hits.delete(0);
         if (want.hit !== found) begin
            faults++;
            $display("%0t: match_found expected %0b, got %0b", $time, want.hit, found);
         end
         if (want.offset !== offset) begin
            faults++;
            $display("%0t: match_offset expected %h, got %h", $time, want.offset, offset);
         end
      endfunction

      function int pending();
         return expected_hits.size();
      endfunction
   endclass

   logic                                   clock      = 1'b0;
   logic                                   reset      = 1'b1;
   logic                                   req_tvalid = 1'b0;
   logic                                   req_tready;
   logic [bdps_pkg::BYTE_BITS-1:0]         req_tdata  = '0;
   logic                                   rsp_tvalid;
   logic                                   rsp_tready = 1'b0;
   logic [bdps_pkg::OFFSET_OUT_BITS-1:0]   rsp_tdata;
   logic                                   rsp_tuser;
   logic                                   csr_we     = 1'b0;
   logic [bdps_pkg::CSR_INDEX_BITS-1:0]    csr_index  = bdps_pkg::CSR_PATTERN_LENGTH;
   logic [bdps_pkg::CSR_DATA_BITS-1:0]     csr_wdata  = '0;

   diff_match_predictor  sb;
   int unsigned          burst_left  = 0;
   int unsigned          gap_left    = 0;
   int unsigned          bytes_sent  = 0;
   int unsigned          idle_cycles = 0;
   int unsigned          rsp_cycle   = 0;

   byte_difference_pattern_search_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // beat tracking, rsp stall pattern and watchdog
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.absorb_byte(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tuser, rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      rsp_cycle <= rsp_cycle + 1;
      case (rsp_cycle[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (rsp_cycle[2:0] < 3'd5);
         default: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   task automatic push_byte(input logic [bdps_pkg::BYTE_BITS-1:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_left) @(posedge clock);
         gap_left = 0;
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic write_csr(input logic [bdps_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [bdps_pkg::CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_register(idx, value);
      @(posedge clock);
   endtask

   // upper bits of the length and high-difference words are junk on purpose
   task automatic configure(input logic [bdps_pkg::LEN_BITS-1:0] len,
                            input logic [bdps_pkg::DIFFS_LOW_BITS-1:0] low,
                            input logic [bdps_pkg::DIFFS_HIGH_BITS-1:0] high);
      logic [bdps_pkg::CSR_DATA_BITS-1:0] word;
      word = {$urandom, $urandom};
      word[bdps_pkg::LEN_BITS-1:0] = len;
      write_csr(bdps_pkg::CSR_PATTERN_LENGTH, word);
      write_csr(bdps_pkg::CSR_DIFFS_LOW, low);
      word = {$urandom, $urandom};
      word[bdps_pkg::DIFFS_HIGH_BITS-1:0] = high;
      write_csr(bdps_pkg::CSR_DIFFS_HIGH, word);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // run of len+1 bytes following the pattern; a broken run has one byte after the first corrupted
   task automatic send_chain(input int unsigned len, input bit broken);
      logic [bdps_pkg::BYTE_BITS-1:0] value;
      int unsigned                    bad_pos;
      value   = bdps_pkg::BYTE_BITS'($urandom);
      bad_pos = broken ? $urandom_range(1, len) : 0;
      push_byte(value);
      for (int i = 0; i < len; i++) begin
         value = value + sb.step_at(i);
         if (i + 1 == bad_pos) begin
            push_byte(value + bdps_pkg::BYTE_BITS'($urandom_range(1, 255)));
         end else begin
            push_byte(value);
         end
      end
   endtask

   task automatic run_phase(input int unsigned len,
                            input logic [bdps_pkg::DIFFS_LOW_BITS-1:0] low,
                            input logic [bdps_pkg::DIFFS_HIGH_BITS-1:0] high);
      int unsigned start;
      int unsigned pick;
      settle();
      configure(bdps_pkg::LEN_BITS'(len), low, high);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BEATS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            send_chain(len, 1'b0);
         end else if (pick < 8) begin
            send_chain(len, 1'b1);
         end else begin
            repeat ($urandom_range(1, len + 1)) push_byte(bdps_pkg::BYTE_BITS'($urandom));
         end
      end
   endtask

   initial begin
      int unsigned                          phase_len [11];
      logic [bdps_pkg::DIFFS_LOW_BITS-1:0]  low;
      logic [bdps_pkg::DIFFS_HIGH_BITS-1:0] high;
      phase_len = '{1, 2, 3, 5, 7, 5, 7, 9, 12, 14, 15};
      sb = new;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // unmapped index must be ignored; zero length never matches
      write_csr(CSR_UNMAPPED, '1);
      configure(4'd0, '1, '1);
      push_byte(8'hFF);
      push_byte(8'hFE);
      push_byte(8'hFD);
      push_byte(8'h00);
      push_byte(8'h80);

      settle();
      configure(4'd1, 64'h01, '0);
      push_byte(8'h7F);
      push_byte(8'h80);
      push_byte(8'hFF);
      push_byte(8'h00);

      settle();
      configure(4'd2, 64'h00FF, '0);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'hFF);
      push_byte(8'h55);
      push_byte(8'hAA);

      // lengths mostly rise; the second 5 is a shrink and must stay silent
      for (int p = 0; p < 11; p++) begin
         if (p == 2) begin
            low  = '0;
            high = '0;
         end else if (p == 4 || p == 9) begin
            low  = '1;
            high = '1;
         end else begin
            low  = {$urandom, $urandom};
            high = bdps_pkg::DIFFS_HIGH_BITS'({$urandom, $urandom});
         end
         run_phase(phase_len[p], low, high);
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
